// ===== rtl/rgbwcf_pkg.sv =====
// Shared types, constants and command/status structs for the RGBW crossfade block.
package rgbwcf_pkg;

  localparam int COLOR_W   = 16;
  localparam int SPEED_W   = 25;
  localparam int ELAPSED_W = 20;
  localparam int LEVEL_W   = 8;
  localparam int BRIGHT_W  = 17;
  localparam int PHASE_W   = 24;   // fade phase stays below one
  localparam int PHASE_FRAC = 24;
  localparam int BRIGHT_FRAC = 16;
  localparam int NUM_CHAN  = 4;    // red, green, blue, white
  localparam int NUM_LIT   = 3;    // channels scaled by brightness
  localparam int MUL_W     = 26;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CNT_W     = 5;
  localparam int DIV_CONST = 1000;
  localparam int MAX_LEVEL = 255;
  localparam int LEVEL_COUNT = 1 << LEVEL_W;
  localparam int BRIGHT_ONE_INT = 1 << BRIGHT_FRAC;

  // divide by 1000: drop the factor 8, then multiply by the reciprocal of 125
  localparam int DIV_PRE_SHIFT = 3;
  localparam int QDIV_W        = 31;   // step product below 1000 * 2^24, shifted by 3
  localparam int RECIP_W       = 29;
  localparam int RECIP_SHIFT   = 35;
  localparam int RCP_W         = QDIV_W + RECIP_W;

  localparam logic [SPEED_W-1:0]  PHASE_ONE    = SPEED_W'(1 << PHASE_FRAC);
  localparam logic [SPEED_W-1:0]  SPEED_RESET  = SPEED_W'(16777);
  localparam logic [BRIGHT_W-1:0] BRIGHT_ONE   = BRIGHT_W'(BRIGHT_ONE_INT);
  localparam logic [45:0]         SAT_LIMIT    = 46'(DIV_CONST) << PHASE_FRAC;
  // ceil(2^35 / 125), exact for every dividend below 2^31
  localparam logic [RECIP_W-1:0]  RECIP_125    = RECIP_W'(274877907);

  typedef logic [BRIGHT_W-1:0] bright_tbl_t [LEVEL_COUNT];

  // level -> brightness target, level clamped to MAX_LEVEL
  function automatic bright_tbl_t build_bright_tbl();
    bright_tbl_t t;
    int l;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      l = (i > MAX_LEVEL) ? MAX_LEVEL : i;
      t[i] = BRIGHT_W'((l * BRIGHT_ONE_INT) / MAX_LEVEL);
    end
    return t;
  endfunction

  localparam bright_tbl_t BRIGHT_TBL = build_bright_tbl();

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_COLOR  = 2'd1,
    REQ_BRIGHT = 2'd2,
    REQ_SPEED  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MUL_STEP,
    MUL_BRIGHT,
    MUL_RAW,
    MUL_SCALE
  } mul_sel_t;

  typedef struct packed {
    logic       load_item;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic [1:0] mul_chan;
    logic       div_init;
    logic       step_take;
    logic       bright_adv;
    logic       bright_take;
    logic       fade_adv;
    logic       raw_take;
    logic       scale_take;
    logic [1:0] take_chan;
    logic       apply_color;
    logic       apply_bright;
    logic       apply_speed;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic first_tick;
    logic step_sat;
    logic bright_moving;
  } stat_t;

endpackage

// ===== rtl/rgbwcf_dp.sv =====
// Datapath: color/brightness state, shared multiplier, divide-by-1000 unit, output registers.
module rgbwcf_dp import rgbwcf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [SPEED_W-1:0]   cfg_data,
  input  logic [1:0]           req_type,
  input  logic [ELAPSED_W-1:0] elapsed_us,
  input  logic [COLOR_W-1:0]   new_red,
  input  logic [COLOR_W-1:0]   new_green,
  input  logic [COLOR_W-1:0]   new_blue,
  input  logic [COLOR_W-1:0]   new_white,
  input  logic [LEVEL_W-1:0]   level,
  input  logic [SPEED_W-1:0]   speed_code,
  input  logic                 use_default_speed,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic [COLOR_W-1:0]   out_red,
  output logic [COLOR_W-1:0]   out_green,
  output logic [COLOR_W-1:0]   out_blue,
  output logic [COLOR_W-1:0]   out_white,
  output logic                 fade_done
);

  // captured request
  req_t                 item_req;
  logic [ELAPSED_W-1:0] item_elapsed;
  logic [COLOR_W-1:0]   item_color [NUM_CHAN];
  logic [LEVEL_W-1:0]   item_level;
  logic [SPEED_W-1:0]   item_speed;
  logic                 item_use_def;

  // architectural state
  logic [SPEED_W-1:0]   default_speed;
  logic [SPEED_W-1:0]   cur_speed;
  logic [COLOR_W-1:0]   start_col [NUM_CHAN];
  logic [COLOR_W-1:0]   target_col [NUM_CHAN];
  logic [PHASE_W-1:0]   fade_phase;
  logic [BRIGHT_W-1:0]  bright_now;
  logic [BRIGHT_W-1:0]  bright_start;
  logic [BRIGHT_W-1:0]  bright_target;
  logic [SPEED_W-1:0]   bright_phase;
  logic                 ticked;

  // working registers
  logic [SPEED_W-1:0]   step;
  logic signed [PROD_W-1:0] prod;
  logic [RCP_W-1:0]     rcp_prod;
  logic [COLOR_W-1:0]   s_hold;
  logic [COLOR_W-1:0]   raw [NUM_CHAN];
  logic [COLOR_W-1:0]   res_col [NUM_LIT];
  logic                 res_done;

  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic signed [BRIGHT_W-1:0] col_diff;
  logic [BRIGHT_W-1:0]        bdiff_abs;
  logic                       bright_up;
  logic                       step_sat;
  logic [SPEED_W:0]           bsum;
  logic [SPEED_W:0]           fsum;
  logic [BRIGHT_W-1:0]        bdelta;
  logic signed [COLOR_W+1:0]  raw_sum;
  logic [BRIGHT_W-1:0]        scaled;

  assign bright_up = bright_target >= bright_start;
  assign bdiff_abs = bright_up ? (bright_target - bright_start) : (bright_start - bright_target);
  assign col_diff  = $signed({1'b0, target_col[cmd.mul_chan]})
                   - $signed({1'b0, start_col[cmd.mul_chan]});
  assign step_sat  = prod[45:0] >= SAT_LIMIT;

  always_comb begin
    case (cmd.mul_sel)
      MUL_STEP: begin
        mul_a = $signed({1'b0, cur_speed});
        mul_b = $signed({{(MUL_W-ELAPSED_W){1'b0}}, item_elapsed});
      end
      MUL_BRIGHT: begin
        mul_a = $signed({1'b0, bright_phase});
        mul_b = $signed({{(MUL_W-BRIGHT_W){1'b0}}, bdiff_abs});
      end
      MUL_RAW: begin
        mul_a = $signed({{(MUL_W-PHASE_W){1'b0}}, fade_phase});
        mul_b = $signed({{(MUL_W-BRIGHT_W){col_diff[BRIGHT_W-1]}}, col_diff});
      end
      MUL_SCALE: begin
        mul_a = $signed({{(MUL_W-COLOR_W){1'b0}}, raw[cmd.mul_chan]});
        mul_b = $signed({{(MUL_W-BRIGHT_W){1'b0}}, bright_now});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign bsum    = {1'b0, bright_phase} + {1'b0, step};
  assign fsum    = (SPEED_W+1)'(fade_phase) + {1'b0, step};
  assign bdelta  = prod[40:24];
  assign raw_sum = $signed({2'b0, s_hold}) + $signed(prod[41:24]);
  assign scaled  = prod[32:16];

  assign stat.req           = item_req;
  assign stat.first_tick    = !ticked;
  assign stat.step_sat      = step_sat;
  assign stat.bright_moving = bright_start != bright_target;

  // state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      default_speed <= SPEED_RESET;
      cur_speed     <= SPEED_RESET;
      fade_phase    <= '0;
      bright_now    <= BRIGHT_ONE;
      bright_start  <= BRIGHT_ONE;
      bright_target <= BRIGHT_ONE;
      bright_phase  <= '0;
      ticked        <= 1'b0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        start_col[c]  <= '0;
        target_col[c] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        default_speed <= cfg_data;
      end
      if (cmd.step_take) begin
        ticked <= 1'b1;
      end
      if (cmd.bright_adv) begin
        bright_phase <= (bsum > (SPEED_W+1)'(PHASE_ONE)) ? PHASE_ONE : bsum[SPEED_W-1:0];
      end
      if (cmd.bright_take) begin
        bright_now <= bright_up ? (bright_start + bdelta) : (bright_start - bdelta);
        if (bright_phase == PHASE_ONE) begin
          bright_start <= bright_target;
        end
      end
      if (cmd.fade_adv) begin
        if (fsum >= (SPEED_W+1)'(PHASE_ONE)) begin
          for (int c = 0; c < NUM_CHAN; c++) begin
            start_col[c] <= target_col[c];
          end
          fade_phase <= '0;
        end else begin
          fade_phase <= fsum[PHASE_W-1:0];
        end
      end
      if (cmd.apply_color) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          start_col[c]  <= raw[c];
          target_col[c] <= item_color[c];
        end
        fade_phase <= '0;
      end
      if (cmd.apply_bright) begin
        cur_speed     <= item_use_def ? default_speed : item_speed;
        bright_start  <= bright_now;
        bright_target <= BRIGHT_TBL[item_level];
        bright_phase  <= '0;
      end
      if (cmd.apply_speed) begin
        cur_speed <= item_speed;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_req      <= req_t'(req_type);
      item_elapsed  <= elapsed_us;
      item_color[0] <= new_red;
      item_color[1] <= new_green;
      item_color[2] <= new_blue;
      item_color[3] <= new_white;
      item_level    <= level;
      item_speed    <= speed_code;
      item_use_def  <= use_default_speed;
      res_done      <= 1'b0;
    end
    if (cmd.mul_en) begin
      prod   <= mul_a * mul_b;
      s_hold <= start_col[cmd.mul_chan];
    end
    // unsaturated step product is below 1000 * 2^24, so /8 fits 31 bits
    if (cmd.div_init) begin
      rcp_prod <= RCP_W'(prod[QDIV_W+DIV_PRE_SHIFT-1:DIV_PRE_SHIFT]) * RCP_W'(RECIP_125);
    end
    if (cmd.step_take) begin
      if (!ticked) begin
        step <= (cur_speed > PHASE_ONE) ? PHASE_ONE : cur_speed;
      end else if (step_sat) begin
        step <= PHASE_ONE;
      end else begin
        step <= {1'b0, rcp_prod[RECIP_SHIFT+PHASE_W-1:RECIP_SHIFT]};
      end
    end
    if (cmd.fade_adv && fsum >= (SPEED_W+1)'(PHASE_ONE)) begin
      res_done <= 1'b1;
    end
    if (cmd.raw_take) begin
      raw[cmd.take_chan] <= raw_sum[COLOR_W-1:0];
    end
    if (cmd.scale_take) begin
      res_col[cmd.take_chan] <= scaled[BRIGHT_W-1] ? '1 : scaled[COLOR_W-1:0];
    end
    if (cmd.publish) begin
      out_red   <= res_col[0];
      out_green <= res_col[1];
      out_blue  <= res_col[2];
      out_white <= raw[3];
      fade_done <= res_done;
    end
  end

endmodule

// ===== rtl/rgbwcf_ctrl.sv =====
// Controller: sequences each request through the datapath and runs both handshakes.
module rgbwcf_ctrl import rgbwcf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_STEP,
    S_QUOT,
    S_BRIGHT,
    S_BMUL,
    S_BTAKE,
    S_FADE,
    S_RAW,
    S_APPLY,
    S_SCALE,
    S_PUBLISH
  } state_t;

  localparam logic [CNT_W-1:0] RAW_LAST   = CNT_W'(NUM_CHAN);
  localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(NUM_LIT);

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_m1;
  logic             pre_pass;   // set color: raw pass before the update
  logic             slot_free;

  assign in_ready  = state == S_IDLE;
  assign slot_free = !out_valid || out_ready;
  assign cnt_m1    = cnt - CNT_W'(1);

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_STEP;
    case (state)
      S_IDLE: cmd.load_item = in_valid;
      S_DISPATCH: begin
        case (stat.req)
          REQ_TICK: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_STEP;
          end
          REQ_BRIGHT: cmd.apply_bright = 1'b1;
          REQ_SPEED:  cmd.apply_speed = 1'b1;
          default: ;
        endcase
      end
      S_STEP: begin
        if (stat.first_tick || stat.step_sat) begin
          cmd.step_take = 1'b1;
        end else begin
          cmd.div_init = 1'b1;
        end
      end
      S_QUOT:   cmd.step_take = 1'b1;
      S_BRIGHT: cmd.bright_adv = stat.bright_moving;
      S_BMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BRIGHT;
      end
      S_BTAKE: cmd.bright_take = 1'b1;
      S_FADE:  cmd.fade_adv = 1'b1;
      S_RAW: begin
        // multiply channel cnt while taking channel cnt-1
        cmd.mul_en    = cnt < RAW_LAST;
        cmd.mul_sel   = MUL_RAW;
        cmd.mul_chan  = cnt[1:0];
        cmd.raw_take  = cnt != '0;
        cmd.take_chan = cnt_m1[1:0];
      end
      S_APPLY: cmd.apply_color = 1'b1;
      S_SCALE: begin
        cmd.mul_en     = cnt < SCALE_LAST;
        cmd.mul_sel    = MUL_SCALE;
        cmd.mul_chan   = cnt[1:0];
        cmd.scale_take = cnt != '0;
        cmd.take_chan  = cnt_m1[1:0];
      end
      S_PUBLISH: cmd.publish = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pre_pass  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_PUBLISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          cnt <= '0;
          if (stat.req == REQ_TICK) begin
            state <= S_STEP;
          end else begin
            pre_pass <= stat.req == REQ_COLOR;
            state    <= S_RAW;
          end
        end
        S_STEP: begin
          if (stat.first_tick || stat.step_sat) begin
            state <= S_BRIGHT;
          end else begin
            state <= S_QUOT;
          end
        end
        S_QUOT: state <= S_BRIGHT;
        S_BRIGHT: begin
          if (stat.bright_moving) begin
            state <= S_BMUL;
          end else begin
            state <= S_FADE;
          end
        end
        S_BMUL:  state <= S_BTAKE;
        S_BTAKE: state <= S_FADE;
        S_FADE: begin
          cnt      <= '0;
          pre_pass <= 1'b0;
          state    <= S_RAW;
        end
        S_RAW: begin
          if (cnt == RAW_LAST) begin
            cnt   <= '0;
            state <= pre_pass ? S_APPLY : S_SCALE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_APPLY: begin
          cnt      <= '0;
          pre_pass <= 1'b0;
          state    <= S_RAW;
        end
        S_SCALE: begin
          if (cnt == SCALE_LAST) begin
            cnt   <= '0;
            state <= S_PUBLISH;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_PUBLISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rgbw_crossfade_with_brightness_ramp.sv =====
// RGBW crossfade with brightness ramp: top level joining controller and datapath.
//
// Input channel (in_valid/in_ready): one request per item; req_type selects
// tick, set color, set brightness or set speed. Every request yields exactly
// one result on the output channel (out_valid/out_ready): the RGBW color after
// the request, red/green/blue scaled by the current brightness, plus fade_done.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes default_speed; it is
// always ready and should only be written while no request is in flight.
// A tick also runs the brightness multiply states while brightness ramps, and
// a quotient state when its step needs the divide by 1000, done as a shift by 3
// and a constant multiply by the reciprocal of 125. One shared 26x26 multiplier
// handles the step, brightness ramp, color interpolation and scaling passes.
// One request is processed at a time; the next is accepted the cycle after
// its result is loaded into the output register.
// A stalled receiver holds the result in the output register; a new request
// may be accepted meanwhile and waits at its final stage until the slot frees.
// Reset (rst, synchronous) clears colors and phases, sets brightness to one
// and both speeds to 16777, and empties the output register.
module rgbw_crossfade_with_brightness_ramp import rgbwcf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type,
  input  logic [ELAPSED_W-1:0] elapsed_us,
  input  logic [COLOR_W-1:0]   new_red,
  input  logic [COLOR_W-1:0]   new_green,
  input  logic [COLOR_W-1:0]   new_blue,
  input  logic [COLOR_W-1:0]   new_white,
  input  logic [LEVEL_W-1:0]   level,
  input  logic [SPEED_W-1:0]   speed_code,
  input  logic                 use_default_speed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COLOR_W-1:0]   out_red,
  output logic [COLOR_W-1:0]   out_green,
  output logic [COLOR_W-1:0]   out_blue,
  output logic [COLOR_W-1:0]   out_white,
  output logic                 fade_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SPEED_W-1:0]   cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rgbwcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rgbwcf_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .req_type          (req_type),
    .elapsed_us        (elapsed_us),
    .new_red           (new_red),
    .new_green         (new_green),
    .new_blue          (new_blue),
    .new_white         (new_white),
    .level             (level),
    .speed_code        (speed_code),
    .use_default_speed (use_default_speed),
    .cmd               (cmd),
    .stat              (stat),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_white         (out_white),
    .fade_done         (fade_done)
  );

endmodule
